/* rtl/core/scanline_edge_intersect_assert.svh */
// Assertion macros shared by the scanline edge intersection RTL.
`ifndef SCANLINE_EDGE_INTERSECT_ASSERT_SVH
`define SCANLINE_EDGE_INTERSECT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SEI_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SEI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sei_pkg.sv */
// Shared widths, sideband type and helpers for the scanline edge intersection block.
package sei_pkg;

  // Coordinate width; the fraction bits cancel in the ratio and change no logic.
  localparam int COORD_WIDTH = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int MAG_WIDTH   = COORD_WIDTH;
  localparam int PROD_WIDTH  = 2 * MAG_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 2;
  localparam int DIV_STEPS   = PROD_WIDTH;

  // Per-item data that rides alongside the divider chain.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x0;
    logic                          neg;
    logic                          hit;
    logic                          horiz;
  } sei_side_t;

  // Magnitude of a coordinate difference; always fits in MAG_WIDTH bits.
  function automatic logic [MAG_WIDTH-1:0] mag_of(input logic signed [DIFF_WIDTH-1:0] v);
    logic [DIFF_WIDTH-1:0] a;
    a = v[DIFF_WIDTH-1] ? -v : v;
    return a[MAG_WIDTH-1:0];
  endfunction

endpackage

/* rtl/core/sei_front.sv */
// Front stages: edge differences, sign and hit flags, then the exact product.
module sei_front
  import sei_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [COORD_WIDTH-1:0] x0_i,
  input  logic signed [COORD_WIDTH-1:0] y0_i,
  input  logic signed [COORD_WIDTH-1:0] x1_i,
  input  logic signed [COORD_WIDTH-1:0] y1_i,
  input  logic signed [COORD_WIDTH-1:0] ys_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [PROD_WIDTH-1:0]         prod_o,
  output logic [MAG_WIDTH-1:0]          div_o,
  output sei_side_t                     side_o
);

  logic signed [DIFF_WIDTH-1:0] dx, dy, dt;
  logic [MAG_WIDTH-1:0]         mdx_d, mdt_d, mdy_d;
  sei_side_t                    side_a_d;

  logic                 a_valid_q, a_en, a_stall;
  logic [MAG_WIDTH-1:0] mdx_q, mdt_q, mdy_q;
  sei_side_t            side_a_q;

  logic                  b_valid_q, b_en;
  logic [PROD_WIDTH-1:0] prod_q;
  logic [MAG_WIDTH-1:0]  mdy_b_q;
  sei_side_t             side_b_q;

  // Form differences, magnitudes and flags
  always_comb begin
    dx = {x1_i[COORD_WIDTH-1], x1_i} - {x0_i[COORD_WIDTH-1], x0_i};
    dy = {y1_i[COORD_WIDTH-1], y1_i} - {y0_i[COORD_WIDTH-1], y0_i};
    dt = {ys_i[COORD_WIDTH-1], ys_i} - {y0_i[COORD_WIDTH-1], y0_i};
    mdx_d = mag_of(dx);
    mdt_d = mag_of(dt);
    mdy_d = mag_of(dy);
    side_a_d.x0    = x0_i;
    side_a_d.neg   = dx[DIFF_WIDTH-1] ^ dt[DIFF_WIDTH-1] ^ dy[DIFF_WIDTH-1];
    side_a_d.horiz = (dy == '0);
    side_a_d.hit   = !side_a_d.horiz &&
                     ((dt == '0) ||
                      ((dt[DIFF_WIDTH-1] == dy[DIFF_WIDTH-1]) && (mdt_d <= mdy_d)));
  end

  // Stage stalls only when full and the next stage stalls
  assign b_en    = !(b_valid_q && stall_i);
  assign a_stall = a_valid_q && !b_en;
  assign a_en    = !a_stall;
  assign stall_o = a_stall;

  // Stage A control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_en) begin
      a_valid_q <= valid_i;
    end
  end

  // Stage A payload
  always_ff @(posedge clk_i) begin
    if (a_en && valid_i) begin
      mdx_q    <= mdx_d;
      mdt_q    <= mdt_d;
      mdy_q    <= mdy_d;
      side_a_q <= side_a_d;
    end
  end

  // Stage B control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_en) begin
      b_valid_q <= a_valid_q;
    end
  end

  // Stage B payload: exact magnitude product
  always_ff @(posedge clk_i) begin
    if (b_en && a_valid_q) begin
      prod_q   <= mdx_q * mdt_q;
      mdy_b_q  <= mdy_q;
      side_b_q <= side_a_q;
    end
  end

  assign valid_o = b_valid_q;
  assign prod_o  = prod_q;
  assign div_o   = mdy_b_q;
  assign side_o  = side_b_q;

endmodule

/* rtl/core/sei_div_cell.sv */
// One restoring-division cell: produces one quotient bit and hands on to the next cell.
`include "scanline_edge_intersect_assert.svh"
module sei_div_cell
  import sei_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [MAG_WIDTH-1:0]  rem_i,
  input  logic [PROD_WIDTH-1:0] nq_i,
  input  logic [MAG_WIDTH-1:0]  div_i,
  input  sei_side_t             side_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic [MAG_WIDTH-1:0]  rem_o,
  output logic [PROD_WIDTH-1:0] nq_o,
  output logic [MAG_WIDTH-1:0]  div_o,
  output sei_side_t             side_o
);

  logic [MAG_WIDTH:0]    trial, diff;
  logic                  qbit;
  logic [MAG_WIDTH-1:0]  rem_d;
  logic [PROD_WIDTH-1:0] nq_d;

  logic                  valid_q, en;
  logic [MAG_WIDTH-1:0]  rem_q, div_q;
  logic [PROD_WIDTH-1:0] nq_q;
  sei_side_t             side_q;

  // Shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    trial = {rem_i, nq_i[PROD_WIDTH-1]};
    diff  = trial - {1'b0, div_i};
    qbit  = (trial >= {1'b0, div_i});
    rem_d = qbit ? diff[MAG_WIDTH-1:0] : trial[MAG_WIDTH-1:0];
    nq_d  = {nq_i[PROD_WIDTH-2:0], qbit};
  end

  assign en      = !(valid_q && stall_i);
  assign stall_o = !en;

  // Hold or advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  // Capture the step result on transfer
  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      div_q  <= div_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

  // Partial remainder stays below the divisor on every real edge
  `SEI_ASSERT_IMPLY(a_rem_below_div, valid_q && !side_q.horiz, rem_q < div_q,
                    "remainder not below divisor")
  `SEI_ASSERT_NEXT(a_rem_step, valid_i && !stall_o && !side_i.horiz && (rem_i < div_i),
                   rem_q < div_q, "division step broke remainder bound")
  // A stalled cell holds its item
  `SEI_ASSERT_NEXT(a_hold_stall, valid_q && stall_i,
                   valid_q && $stable(nq_q) && $stable(rem_q), "stalled cell payload changed")

endmodule

/* rtl/core/sei_back.sv */
// Back stage: apply the quotient sign, add the start x, saturate and hold the result.
`include "scanline_edge_intersect_assert.svh"
module sei_back
  import sei_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [PROD_WIDTH-1:0]         quot_i,
  input  sei_side_t                     side_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] cross_x_o,
  output logic                          on_segment_o,
  output logic                          horizontal_edge_o,
  output logic                          saturated_o
);

  logic [SUM_WIDTH-1:0]   qext, offs, sum;
  logic                   fits;
  logic [COORD_WIDTH-1:0] x_d;
  logic                   sat_d;

  logic                   valid_q, en;
  logic [COORD_WIDTH-1:0] x_q;
  logic                   hit_q, horiz_q, sat_q;

  // Signed offset plus start x, then clamp to the coordinate range
  always_comb begin
    qext = {2'b00, quot_i};
    offs = side_i.neg ? -qext : qext;
    sum  = {{(SUM_WIDTH-COORD_WIDTH){side_i.x0[COORD_WIDTH-1]}}, side_i.x0} + offs;
    fits = (sum[SUM_WIDTH-1:COORD_WIDTH-1] == '0) ||
           (sum[SUM_WIDTH-1:COORD_WIDTH-1] == '1);
    if (side_i.horiz) begin
      x_d   = '0;
      sat_d = 1'b0;
    end else if (fits) begin
      x_d   = sum[COORD_WIDTH-1:0];
      sat_d = 1'b0;
    end else begin
      x_d   = {sum[SUM_WIDTH-1], {(COORD_WIDTH-1){!sum[SUM_WIDTH-1]}}};
      sat_d = 1'b1;
    end
  end

  assign en      = !(valid_q && out_stall_i);
  assign stall_o = !en;

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      x_q     <= x_d;
      hit_q   <= side_i.hit;
      horiz_q <= side_i.horiz;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign cross_x_o         = x_q;
  assign on_segment_o      = hit_q;
  assign horizontal_edge_o = horiz_q;
  assign saturated_o       = sat_q;

  // A clamped crossing can never lie on the edge
  `SEI_ASSERT_IMPLY(a_sat_off_segment, valid_q && sat_q, !hit_q,
                    "saturated crossing flagged on segment")
  // Horizontal edges give a clean zero result
  `SEI_ASSERT_IMPLY(a_horiz_clean, valid_q && horiz_q, (x_q == '0) && !hit_q && !sat_q,
                    "horizontal edge result not cleared")
  // A stalled result holds until its transfer
  `SEI_ASSERT_NEXT(a_out_hold, valid_q && out_stall_i,
                   valid_q && $stable(x_q) && $stable(sat_q), "stalled result changed")

endmodule

/* rtl/core/scanline_edge_intersect.sv */
// Scanline / polygon edge intersection: one edge per cycle unless a stage stalls.
// 35 register stages: front stages A and B, one per divider cell, and the output register.
// Throughput: one edge per cycle unless stalled; each restoring division cell gives one bit.
// Each stage stalls only when it is full and its successor stalls, so bubbles collapse.
// Reset clears only the valid bits of every stage; payload registers are not reset.
module scanline_edge_intersect
  import sei_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] edge_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] edge_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] edge_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] edge_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] scan_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] cross_x_o,
  output logic                          on_segment_o,
  output logic                          horizontal_edge_o,
  output logic                          saturated_o
);

  logic                  valid_c [DIV_STEPS+1];
  logic                  stall_c [DIV_STEPS+1];
  logic [MAG_WIDTH-1:0]  rem_c   [DIV_STEPS+1];
  logic [PROD_WIDTH-1:0] nq_c    [DIV_STEPS+1];
  logic [MAG_WIDTH-1:0]  div_c   [DIV_STEPS+1];
  sei_side_t             side_c  [DIV_STEPS+1];

  // Differences, flags and product
  sei_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .x0_i    (edge_start_x_i),
    .y0_i    (edge_start_y_i),
    .x1_i    (edge_end_x_i),
    .y1_i    (edge_end_y_i),
    .ys_i    (scan_y_i),
    .valid_o (valid_c[0]),
    .stall_i (stall_c[0]),
    .prod_o  (nq_c[0]),
    .div_o   (div_c[0]),
    .side_o  (side_c[0])
  );

  // Division starts from a zero remainder
  assign rem_c[0] = '0;

  // One quotient bit per cell
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    sei_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .stall_o (stall_c[i]),
      .rem_i   (rem_c[i]),
      .nq_i    (nq_c[i]),
      .div_i   (div_c[i]),
      .side_i  (side_c[i]),
      .valid_o (valid_c[i+1]),
      .stall_i (stall_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .nq_o    (nq_c[i+1]),
      .div_o   (div_c[i+1]),
      .side_o  (side_c[i+1])
    );
  end

  // Sign, offset, saturation and output register
  sei_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (valid_c[DIV_STEPS]),
    .stall_o           (stall_c[DIV_STEPS]),
    .quot_i            (nq_c[DIV_STEPS]),
    .side_i            (side_c[DIV_STEPS]),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cross_x_o         (cross_x_o),
    .on_segment_o      (on_segment_o),
    .horizontal_edge_o (horizontal_edge_o),
    .saturated_o       (saturated_o)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the scanline edge intersection pipeline.
`timescale 1ns / 100ps

module tb
  import sei_pkg::*;
();

  localparam int  GAP_MAX     = 3;
  localparam int  RANDOM_EDGES = 1300;
  localparam int  HOLD_AFTER  = 200;     // results seen before the long receiver hold
  localparam int  HOLD_CYCLES = 150;     // well past the pipeline depth
  localparam int  TAIL_CYCLES = 40;      // pipeline depth plus margin
  localparam int  IDLE_LIMIT  = 4000;
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN = -(64'sd1 <<< (COORD_WIDTH - 1));

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t ys;
    bit     drain_first;   // wait until every crossing is back before sending
  } edge_item_t;

  typedef struct packed {
    coord_t cross_x;
    logic   on_segment;
    logic   horizontal_edge;
    logic   saturated;
  } crossing_t;

  logic   clk_i;
  logic   rst_ni         = 1'b0;
  logic   in_valid_i     = 1'b0;
  logic   out_stall_i    = 1'b0;
  coord_t edge_start_x_i = '0;
  coord_t edge_start_y_i = '0;
  coord_t edge_end_x_i   = '0;
  coord_t edge_end_y_i   = '0;
  coord_t scan_y_i       = '0;
  logic   in_stall_o;
  logic   out_valid_o;
  coord_t cross_x_o;
  logic   on_segment_o;
  logic   horizontal_edge_o;
  logic   saturated_o;

  scanline_edge_intersect u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .edge_start_x_i   (edge_start_x_i),
    .edge_start_y_i   (edge_start_y_i),
    .edge_end_x_i     (edge_end_x_i),
    .edge_end_y_i     (edge_end_y_i),
    .scan_y_i         (scan_y_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cross_x_o        (cross_x_o),
    .on_segment_o     (on_segment_o),
    .horizontal_edge_o(horizontal_edge_o),
    .saturated_o      (saturated_o)
  );

  edge_item_t pending_edges[$];
  crossing_t  crossing_expected[$];
  edge_item_t cur_edge;
  int         directed_count;
  int         error_count   = 0;
  int         edges_sent    = 0;
  int         results_seen  = 0;
  int         horiz_seen    = 0;
  int         sat_seen      = 0;
  int         hit_seen      = 0;
  int         gap_left      = 0;
  bit         src_burst     = 1'b0;
  int         wait_left     = 0;
  int         hold_left     = 0;
  bit         hold_done     = 1'b0;
  bit         sink_burst    = 1'b0;
  int         idle_cycles   = 0;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Crossing of the scanline with the line through the edge
  function automatic crossing_t predict_crossing(input edge_item_t e);
    crossing_t r;
    longint    dx, dy, dt, adx, ady, adt, q, xs;
    logic      neg;
    r  = '0;
    dx = longint'(e.x1) - longint'(e.x0);
    dy = longint'(e.y1) - longint'(e.y0);
    dt = longint'(e.ys) - longint'(e.y0);
    if (dy == 0) begin
      r.horizontal_edge = 1'b1;
      return r;
    end
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    adt = (dt < 0) ? -dt : dt;
    q   = (adx * adt) / ady;
    neg = ((dx < 0) != (dt < 0)) != (dy < 0);
    xs  = longint'(e.x0) + (neg ? -q : q);
    if (xs > COORD_MAX) begin
      xs = COORD_MAX;
      r.saturated = 1'b1;
    end else if (xs < COORD_MIN) begin
      xs = COORD_MIN;
      r.saturated = 1'b1;
    end
    r.cross_x    = xs[COORD_WIDTH-1:0];
    r.on_segment = (dt == 0) || (((dt < 0) == (dy < 0)) && (adt <= ady));
    return r;
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t rand_near_zero();
    return coord_t'(int'($urandom_range(0, 127)) - 64);
  endfunction

  // Queue one edge for the driver
  task automatic add_edge(input coord_t x0, input coord_t y0, input coord_t x1,
                          input coord_t y1, input coord_t ys, input bit drain);
    edge_item_t e;
    e.x0 = x0;
    e.y0 = y0;
    e.x1 = x1;
    e.y1 = y1;
    e.ys = ys;
    e.drain_first = drain;
    pending_edges.push_back(e);
  endtask

  // Random edge, mostly with the scanline inside the edge's span
  task automatic add_random_edge(input bit drain);
    int     kind, lo, hi;
    coord_t x0, y0, x1, y1, ys;
    kind = $urandom_range(0, 99);
    x0 = rand_coord();
    y0 = rand_coord();
    x1 = rand_coord();
    y1 = rand_coord();
    ys = rand_coord();
    if (kind < 55) begin
      lo = (y0 < y1) ? int'(y0) : int'(y1);
      hi = (y0 < y1) ? int'(y1) : int'(y0);
      ys = coord_t'(lo + int'($urandom_range(0, hi - lo)));
    end else if (kind < 65) begin
      y1 = y0;
      if ($urandom_range(0, 1)) ys = y0;
    end else if (kind < 80) begin
      // small values stress truncation toward zero
      x0 = rand_near_zero();
      y0 = rand_near_zero();
      x1 = rand_near_zero();
      y1 = rand_near_zero();
      ys = rand_near_zero();
    end else if (kind < 88) begin
      // short edges, far scanline: crossings run out of range
      y1 = coord_t'(y0 + int'($urandom_range(0, 6)) - 3);
    end
    add_edge(x0, y0, x1, y1, ys, drain);
  endtask

  // Stimulus, reset and end of run
  initial begin
    // zero-length edge and horizontal edges
    add_edge(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    add_edge(16'sd5, 16'sd100, 16'sd900, 16'sd100, 16'sd100, 1'b0);
    add_edge(16'sh7fff, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 1'b0);
    add_edge(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    add_edge(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
    // vertical edge and scanline at either endpoint or just past one
    add_edge(16'sd1000, -16'sd500, 16'sd1000, 16'sd500, 16'sd0, 1'b0);
    add_edge(-16'sd300, -16'sd200, 16'sd700, 16'sd800, -16'sd200, 1'b0);
    add_edge(-16'sd300, -16'sd200, 16'sd700, 16'sd800, 16'sd800, 1'b0);
    add_edge(-16'sd300, -16'sd200, 16'sd700, 16'sd800, 16'sd801, 1'b0);
    add_edge(16'sd400, 16'sd800, -16'sd400, -16'sd800, 16'sd0, 1'b0);
    add_edge(16'sd10, 16'sd5, 16'sd20, 16'sd6, 16'sd6, 1'b0);
    // full-range endpoints
    add_edge(-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 16'sd0, 1'b0);
    add_edge(16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
    add_edge(-16'sh8000, -16'sh8000, 16'sh7fff, -16'sh7fff, -16'sh8000, 1'b0);
    add_edge(-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, 16'sh7fff, 1'b0);
    // out-of-range crossings, both bounds, both slopes
    add_edge(16'sd0, 16'sd0, 16'sh7fff, 16'sd1, 16'sh7fff, 1'b0);
    add_edge(16'sd0, 16'sd0, -16'sh8000, 16'sd1, 16'sh7fff, 1'b0);
    add_edge(16'sd0, 16'sd0, 16'sh7fff, -16'sd1, 16'sh7fff, 1'b0);
    add_edge(-16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7ffe, -16'sh8000, 1'b0);
    add_edge(16'sd32000, 16'sd0, 16'sd32100, 16'sd10, 16'sd77, 1'b0);
    // quotients that truncate toward zero
    add_edge(16'sd0, 16'sd0, -16'sd1, 16'sd3, 16'sd1, 1'b0);
    add_edge(16'sd0, 16'sd0, -16'sd2, 16'sd3, 16'sd2, 1'b0);
    add_edge(16'sd7, -16'sd3, 16'sd2, 16'sd4, 16'sd1, 1'b0);
    directed_count = pending_edges.size();

    // random part; drain the pipeline before it and once in the middle
    for (int i = 0; i < RANDOM_EDGES; i++)
      add_random_edge(i == 0 || i == RANDOM_EDGES / 2);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every edge to go out and every crossing to come back
    while (pending_edges.size() > 0 || in_valid_i || crossing_expected.size() > 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (crossing_expected.size() > 0)
      report_mismatch($sformatf("%0d crossings never arrived", crossing_expected.size()));

    $display("Sent %0d edges (%0d directed, rest random) under random gaps and stalls.",
             edges_sent, directed_count);
    $display("Checked %0d crossings: %0d on segment, %0d horizontal, %0d saturated.",
             results_seen, hit_seen, horiz_seen, sat_seen);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Driver: record each transfer, then offer the next edge after its gap
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        crossing_expected.push_back(predict_crossing(cur_edge));
        edges_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_edges.size() > 0 &&
                   !(pending_edges[0].drain_first && crossing_expected.size() > 0)) begin
        cur_edge = pending_edges.pop_front();
        edge_start_x_i <= cur_edge.x0;
        edge_start_y_i <= cur_edge.y0;
        edge_end_x_i   <= cur_edge.x1;
        edge_end_y_i   <= cur_edge.y1;
        scan_y_i       <= cur_edge.ys;
        in_valid_i     <= 1'b1;
        if ($urandom_range(0, 31) == 0) src_burst = !src_burst;
        gap_left = src_burst ? 0 : $urandom_range(0, GAP_MAX);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each transfer against the oldest prediction, then draw the stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (crossing_expected.size() == 0) begin
          report_mismatch($sformatf("crossing x=%0d with no edge pending", cross_x_o));
        end else begin
          crossing_t want;
          want = crossing_expected.pop_front();
          if (cross_x_o !== want.cross_x)
            report_mismatch($sformatf("result %0d cross_x got %0d want %0d",
                                      results_seen, cross_x_o, want.cross_x));
          if (on_segment_o !== want.on_segment)
            report_mismatch($sformatf("result %0d on_segment got %b want %b",
                                      results_seen, on_segment_o, want.on_segment));
          if (horizontal_edge_o !== want.horizontal_edge)
            report_mismatch($sformatf("result %0d horizontal_edge got %b want %b",
                                      results_seen, horizontal_edge_o, want.horizontal_edge));
          if (saturated_o !== want.saturated)
            report_mismatch($sformatf("result %0d saturated got %b want %b",
                                      results_seen, saturated_o, want.saturated));
          hit_seen   += want.on_segment;
          horiz_seen += want.horizontal_edge;
          sat_seen   += want.saturated;
        end
        results_seen++;
        if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
        wait_left = sink_burst ? 0 : $urandom_range(0, GAP_MAX);
        // hold off once for long enough that the pipeline backs up
        if (results_seen == HOLD_AFTER && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
